### design/swad_pkg.sv
// Shared types and constants for the sliding-window anomaly event detector.
// No dependencies; the merge, queue and top-level files refer to this package by scoped names.
package swad_pkg;

    // Event counter width and saturation point.
    localparam int          COUNT_W   = 11;
    localparam logic [10:0] COUNT_CAP = 11'h7FF;

    // Configuration register width and register select codes (paddr[2]).
    localparam int   CFG_W      = 11;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MIN    = 1'b1;

    // Result queue geometry. Room means space for two in-flight items of two results each.
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_ROOM  = 4;

    // Control bits of the item held in the count/merge stage.
    typedef struct packed {
        logic vld;
        logic flag;
        logic last;
        logic drop;
        logic full;
    } t_slot_ctl;

    // One result: event bounds and the final-of-run mark.
    typedef struct packed {
        logic [15:0] evt_start;
        logic [15:0] evt_end;
        logic        fin;
    } t_evt;

endpackage

### design/swad_ring.sv
// Flag ring: single-bit synchronous memory, one write and one read port.
// Read-first on address collision; read data registered. No package dependency.
module swad_ring #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/swad_merge.sv
// Count update and event merge stage: holds the window count and pending event.
// Depends on swad_pkg (t_slot_ctl, t_evt, count constants).
module swad_merge #(
    parameter int SI = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swad_pkg::t_slot_ctl i_ctl,
    input  logic [SI-1:0]       i_idx,
    input  logic [SI-1:0]       i_ws,
    input  logic                i_drop_flag,
    input  logic [10:0]         i_min_count,
    output logic                o_push0,
    output swad_pkg::t_evt      o_evt0,
    output logic                o_push1,
    output swad_pkg::t_evt      o_evt1
);

    logic [swad_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                         r_pend, n_pend;
    logic [SI-1:0]                r_pstart, n_pstart;
    logic [SI-1:0]                r_pend_end, n_pend_end;

    logic [swad_pkg::COUNT_W-1:0] dec_cnt;
    logic                         qual;
    logic                         extend;
    logic                         gap;
    logic                         flush;
    logic                         upd_pend;
    logic [SI-1:0]                upd_start;
    logic [SI-1:0]                upd_end;
    logic [31:0]                  old_s32, old_e32, new_s32, new_e32;

    always_comb begin
        dec_cnt = (i_ctl.drop && i_drop_flag && (r_cnt != '0)) ? r_cnt - 1'b1 : r_cnt;
        n_cnt   = (i_ctl.flag && (dec_cnt != swad_pkg::COUNT_CAP)) ? dec_cnt + 1'b1 : dec_cnt;

        qual   = i_ctl.full && (n_cnt >= i_min_count);
        extend = qual && r_pend && (i_ws <= r_pend_end);
        gap    = qual && r_pend && !extend;

        upd_pend  = r_pend;
        upd_start = r_pstart;
        upd_end   = r_pend_end;
        if (extend) begin
            upd_end = i_idx;
        end else if (qual) begin
            upd_pend  = 1'b1;
            upd_start = i_ws;
            upd_end   = i_idx;
        end

        flush = i_ctl.last && upd_pend;

        // Series end restarts everything held here.
        if (i_ctl.last) begin
            n_pend     = 1'b0;
            n_pstart   = '0;
            n_pend_end = '0;
        end else begin
            n_pend     = upd_pend;
            n_pstart   = upd_start;
            n_pend_end = upd_end;
        end

        old_s32 = 32'(r_pstart);
        old_e32 = 32'(r_pend_end);
        new_s32 = 32'(upd_start);
        new_e32 = 32'(upd_end);

        // Closed event goes first; the flushed one follows and ends the run.
        o_push0 = i_ctl.vld && (gap || flush);
        o_push1 = i_ctl.vld && gap && flush;
        if (gap) begin
            o_evt0 = '{evt_start: old_s32[15:0], evt_end: old_e32[15:0], fin: !flush};
        end else begin
            o_evt0 = '{evt_start: new_s32[15:0], evt_end: new_e32[15:0], fin: 1'b1};
        end
        o_evt1 = '{evt_start: new_s32[15:0], evt_end: new_e32[15:0], fin: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pend     <= 1'b0;
            r_pstart   <= '0;
            r_pend_end <= '0;
        end else if (i_ctl.vld) begin
            r_cnt      <= i_ctl.last ? '0 : n_cnt;
            r_pend     <= n_pend;
            r_pstart   <= n_pstart;
            r_pend_end <= n_pend_end;
        end
    end

endmodule

### design/swad_ofifo.sv
// Result queue: takes up to two events per cycle, hands one per transfer.
// Depends on swad_pkg (t_evt, queue geometry).
module swad_ofifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push0,
    input  swad_pkg::t_evt i_evt0,
    input  logic           i_push1,
    input  swad_pkg::t_evt i_evt1,
    input  logic           i_pop,
    output logic           o_valid,
    output swad_pkg::t_evt o_evt,
    output logic           o_room
);

    swad_pkg::t_evt r_q [swad_pkg::OFIFO_DEPTH];

    logic [swad_pkg::OFIFO_AW-1:0] r_wp, n_wp;
    logic [swad_pkg::OFIFO_AW-1:0] r_rp, n_rp;
    logic [swad_pkg::OFIFO_AW:0]   r_cnt, n_cnt;
    logic [swad_pkg::OFIFO_AW-1:0] wp1;
    logic                          pop;

    always_comb begin
        pop   = i_pop && (r_cnt != '0);
        wp1   = r_wp + 1'b1;
        n_wp  = r_wp + swad_pkg::OFIFO_AW'(i_push0) + swad_pkg::OFIFO_AW'(i_push1);
        n_rp  = r_rp + swad_pkg::OFIFO_AW'(pop);
        n_cnt = r_cnt + (swad_pkg::OFIFO_AW + 1)'(i_push0)
                      + (swad_pkg::OFIFO_AW + 1)'(i_push1)
                      - (swad_pkg::OFIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_q[r_wp] <= i_evt0;
        end
        if (i_push1) begin
            r_q[wp1] <= i_evt1;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_q[r_rp];
    assign o_room  = ((swad_pkg::OFIFO_AW + 1)'(swad_pkg::OFIFO_DEPTH) - r_cnt)
                     >= (swad_pkg::OFIFO_AW + 1)'(swad_pkg::OFIFO_ROOM);

endmodule

### design/sliding_window_anomaly_event_detector_unit.sv
// Anomaly event detector top level; uses swad_pkg, swad_ring, swad_merge and swad_ofifo.
// Throughput: one slot per cycle; input holds off while more than four results wait in the
// queue. Each slot passes the stage register and count/merge logic into the queue, from which
// its result is offered; a second result of that slot follows once the first is taken.
// Reset (synchronous, active low) clears pointers, counters, the pending event and the queue;
// the ring is not cleared, so no clearing pass runs and the block is ready right after reset.
module sliding_window_anomaly_event_detector_unit #(
    parameter int WINDOW_MAX = 1024,
    parameter int SERIES_MAX = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata [0] anomalous, [7:1] zero; tlast = series_end
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // master stream: tdata [15:0] event_start, [31:16] event_end; tlast = final_of_run
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int SI = $clog2(SERIES_MAX);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [swad_pkg::CFG_W-1:0] r_window_size;
    logic [swad_pkg::CFG_W-1:0] r_min_count;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swad_pkg::CFG_W'(1);
            r_min_count   <= swad_pkg::CFG_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                swad_pkg::REG_WINDOW: r_window_size <= pwdata[swad_pkg::CFG_W-1:0];
                swad_pkg::REG_MIN:    r_min_count   <= pwdata[swad_pkg::CFG_W-1:0];
                default:              r_min_count   <= r_min_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            swad_pkg::REG_WINDOW: prdata = 32'(r_window_size);
            swad_pkg::REG_MIN:    prdata = 32'(r_min_count);
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Slot stage: ring pointer, slot index, ring read/write addresses
    // ---------------------------------------------------------------
    logic [AW-1:0]       r_ptr;
    logic [SI-1:0]       r_slot;
    logic [WW-1:0]       w_eff;
    logic [31:0]         w32, ptr32, slot32, old32, ws32;
    logic                accept;
    logic                room;
    logic [AW-1:0]       old_addr;
    logic                drop_flag;

    swad_pkg::t_slot_ctl r_s1;
    logic [SI-1:0]       r_s1_idx;
    logic [SI-1:0]       r_s1_ws;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    always_comb begin
        // Zero window means one slot; clamp to the ring depth.
        if (r_window_size == '0) begin
            w32 = 32'd1;
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w32 = 32'(WINDOW_MAX);
        end else begin
            w32 = 32'(r_window_size);
        end
        w_eff  = WW'(w32);
        ptr32  = 32'(r_ptr);
        slot32 = 32'(r_slot);
        // Slot leaving the window sits w entries behind the write pointer.
        if (ptr32 >= 32'(w_eff)) begin
            old32 = ptr32 - 32'(w_eff);
        end else begin
            old32 = ptr32 + 32'(WINDOW_MAX) - 32'(w_eff);
        end
        old_addr = AW'(old32);
        ws32     = slot32 + 32'd1 - 32'(w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_ptr  <= '0;
                r_slot <= '0;
            end else begin
                r_ptr  <= (r_ptr == AW'(WINDOW_MAX - 1)) ? '0 : r_ptr + 1'b1;
                // Hold the index at its top value on overlong series.
                if (slot32 < 32'(SERIES_MAX - 1)) begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    // Stage register feeding the count/merge stage; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= accept;
        end
        if (accept) begin
            r_s1.flag <= s_axis_tdata[0];
            r_s1.last <= s_axis_tlast;
            r_s1.drop <= slot32 >= w32;
            r_s1.full <= (slot32 + 32'd1) >= w32;
            r_s1_idx  <= r_slot;
            r_s1_ws   <= SI'(ws32);
        end
    end

    // Write this slot's flag and fetch the leaving flag in the same cycle; the
    // ring returns the stored value before the write when both addresses match.
    swad_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_ptr),
        .i_wdata (s_axis_tdata[0]),
        .i_re    (accept),
        .i_raddr (old_addr),
        .o_rdata (drop_flag)
    );

    // ---------------------------------------------------------------
    // Count/merge stage
    // ---------------------------------------------------------------
    logic           push0, push1;
    swad_pkg::t_evt evt0, evt1;

    swad_merge #(
        .SI (SI)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1),
        .i_idx       (r_s1_idx),
        .i_ws        (r_s1_ws),
        .i_drop_flag (drop_flag),
        .i_min_count (r_min_count),
        .o_push0     (push0),
        .o_evt0      (evt0),
        .o_push1     (push1),
        .o_evt1      (evt1)
    );

    // ---------------------------------------------------------------
    // Result queue: decouples the two sides; input stalls when the
    // queue cannot take the worst case of two slots in flight.
    // ---------------------------------------------------------------
    swad_pkg::t_evt out_evt;

    swad_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_evt0  (evt0),
        .i_push1 (push1),
        .i_evt1  (evt1),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_evt   (out_evt),
        .o_room  (room)
    );

    assign m_axis_tdata = {out_evt.evt_end, out_evt.evt_start};
    assign m_axis_tlast = out_evt.fin;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_series_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> (r_ptr == '0) && (r_slot == '0))
        else $error("ring pointer or slot index not cleared after series end");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push1 |-> push0 && !evt0.fin && evt1.fin)
        else $error("second result without an unmarked first result");

    a_stage_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1.vld)
        else $error("accepted slot did not reach the count stage");

endmodule
